[src/homing_particle_step_assert.svh]
// Assertion macros for the homing particle step block.
// Used by the top level only; no other dependencies.
`ifndef HOMING_PARTICLE_STEP_ASSERT_SVH
`define HOMING_PARTICLE_STEP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HPS_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`else
`define HPS_ASSERT_IMPL(label, clk, rst_n, prop)
`endif
`ifndef NO_ASSERTIONS
`define HPS_ASSERT_STABLE(label, clk, rst_n, sig) \
  label: assert property (@(posedge clk) disable iff (!rst_n) \
    (!$past(sig)) |-> 1'b1) else $error("assertion failed");
`else
`define HPS_ASSERT_STABLE(label, clk, rst_n, sig)
`endif
`endif

[src/hps_pkg.sv]
// Package for the homing particle step block: types, constants and
// the controller's state encoding; used by the controller and the datapath.
package hps_pkg;
  localparam int Frac = 16;
  localparam int ValW = 20;
  localparam int IdxW = 8;
  localparam int DivW = 16;
  localparam logic [16:0] DecayQ = 17'd19661;
  localparam logic [16:0] DampQ = 17'd58982;
  localparam logic [20:0] ArriveQ = 21'd262;
  localparam logic [15:0] DivReset = 16'd100;
  localparam logic CmdStart = 1'b0;
  localparam int SqrtSteps = 22;
  localparam int DivSteps = 37;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_LOAD, ST_SQRT, ST_DEN, ST_DIVX, ST_DIVY,
    ST_ACC, ST_VEL, ST_DAMP, ST_POS, ST_DONE
  } state_e;

  typedef struct packed {
    logic rd;
    logic diff;
    logic load;
    logic sqrt_en;
    logic den;
    logic divx_init;
    logic divx_en;
    logic divy_init;
    logic divy_en;
    logic acc;
    logic vel;
    logic damp;
    logic pos;
    logic wr_start;
    logic wr_step;
  } cmd_t;

  typedef struct packed {
    logic last;
  } stat_t;

  function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
    if (v > 24'sd524287) return 20'sh7FFFF;
    if (v < -24'sd524288) return 20'sh80000;
    return v[19:0];
  endfunction

  function automatic logic signed [20:0] mulc(input logic signed [20:0] a,
                                              input logic [16:0] c);
    logic [20:0] m;
    logic [37:0] p;
    m = a[20] ? 21'(-a) : 21'(a);
    p = 38'(m) * 38'(c);
    return a[20] ? -21'(p >> Frac) : 21'(p >> Frac);
  endfunction
endpackage

[src/hps_ctrl.sv]
// Controller state machine for the homing particle step block.
// Depends on hps_pkg; drives datapath commands, counts iterations.
module hps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           cmd_i,
  output logic           busy,
  output logic           done_o,
  output hps_pkg::cmd_t  cmd_o
);
  import hps_pkg::*;
  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [5:0] lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  assign lim = (state_q == ST_SQRT) ? 6'(SqrtSteps - 1) : 6'(DivSteps - 1);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    busy = 1'b1;
    done_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (cmd_i == CmdStart) begin
            cmd_o.wr_start = 1'b1;
            state_d = ST_DONE;
          end else begin
            cmd_o.rd = 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.diff = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        cnt_d = '0;
        state_d = ST_SQRT;
      end
      ST_SQRT, ST_DIVX, ST_DIVY: begin
        cmd_o.sqrt_en = (state_q == ST_SQRT);
        cmd_o.divx_en = (state_q == ST_DIVX);
        cmd_o.divy_en = (state_q == ST_DIVY);
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == lim) begin
          cnt_d = '0;
          state_d = (state_q == ST_SQRT) ? ST_DEN :
                    (state_q == ST_DIVX) ? ST_DIVY : ST_ACC;
          cmd_o.divy_init = (state_q == ST_DIVX);
        end
      end
      ST_DEN: begin
        cmd_o.den = 1'b1;
        state_d = ST_DIVX;
        cmd_o.divx_init = 1'b1;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d = ST_VEL;
      end
      ST_VEL: begin
        cmd_o.vel = 1'b1;
        state_d = ST_DAMP;
      end
      ST_DAMP: begin
        cmd_o.damp = 1'b1;
        state_d = ST_POS;
      end
      ST_POS: begin
        cmd_o.pos = 1'b1;
        cmd_o.wr_step = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        done_o = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

[src/hps_datapath.sv]
// Datapath of the homing particle step block: particle memories,
// iterative square root and divider, update arithmetic. Uses hps_pkg.
module hps_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hps_pkg::cmd_t        cmd_i,
  input  logic                 start,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_data_i,
  input  logic [7:0]           particle_index_i,
  input  logic signed [19:0]   source_x_i,
  input  logic signed [19:0]   source_y_i,
  input  logic signed [19:0]   target_x_i,
  input  logic signed [19:0]   target_y_i,
  output logic [7:0]           result_index_o,
  output logic signed [19:0]   position_x_o,
  output logic signed [19:0]   position_y_o,
  output logic                 arrived_o
);
  import hps_pkg::*;

  logic [119:0] mem [256];
  logic [119:0] rd_q;
  logic [7:0] idx_q;
  logic signed [19:0] tx_q, ty_q;
  logic [15:0] div_q;
  logic signed [20:0] dx_q, dy_q;
  logic signed [19:0] px_q, py_q, vx_q, vy_q, ax_q, ay_q;
  logic [41:0] rem_q;
  logic [21:0] root_q;
  logic [43:0] sq_q;
  logic [37:0] den_q;
  logic [36:0] num_q, quo_q;
  logic [37:0] drem_q;
  logic signed [37:0] qx_q;
  logic [15:0] divisor;
  logic [41:0] trial;
  logic [38:0] dtrial;
  logic [20:0] adx, ady;
  logic signed [19:0] px_n, py_n;

  function automatic logic [36:0] quo_q_next_fn(input logic [36:0] q,
                                                input logic [38:0] t);
    return {q[35:0], ~t[38]};
  endfunction

  function automatic logic signed [23:0] sat_q(input logic signed [37:0] v);
    if (v > 38'sd524287) return 24'sd524287;
    if (v < -38'sd524288) return -24'sd524288;
    return 24'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) div_q <= DivReset;
    else if (cfg_we_i) div_q <= cfg_data_i;
  end

  // The new position is written back in the same cycle as it is registered.
  assign px_n = sat20(24'(px_q) + 24'(vx_q));
  assign py_n = sat20(24'(py_q) + 24'(vy_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) rd_q <= mem[particle_index_i];
    if (cmd_i.wr_start)
      mem[particle_index_i] <= {source_x_i, source_y_i, 80'd0};
    else if (cmd_i.wr_step)
      mem[idx_q] <= {px_n, py_n, vx_q, vy_q, ax_q, ay_q};
  end

  assign divisor = (div_q == 16'd0) ? 16'd1 : div_q;
  assign adx = dx_q[20] ? 21'(-dx_q) : 21'(dx_q);
  assign ady = dy_q[20] ? 21'(-dy_q) : 21'(dy_q);
  assign trial = {rem_q[39:0], sq_q[43:42]} - {18'd0, root_q, 2'b01};
  assign dtrial = {drem_q, num_q[36]} - {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (start && cmd_i.wr_start) begin
      idx_q <= particle_index_i;
      px_q <= source_x_i;
      py_q <= source_y_i;
      arrived_o <= 1'b0;
    end
    if (cmd_i.rd) begin
      idx_q <= particle_index_i;
      tx_q <= target_x_i;
      ty_q <= target_y_i;
    end
    if (cmd_i.diff) begin
      dx_q <= 21'(tx_q) - 21'(signed'(rd_q[119:100]));
      dy_q <= 21'(ty_q) - 21'(signed'(rd_q[99:80]));
    end
    if (cmd_i.load) begin
      {px_q, py_q, vx_q, vy_q, ax_q, ay_q} <= rd_q;
      sq_q <= 44'(dx_q * dx_q) + 44'(dy_q * dy_q);
      rem_q <= '0;
      root_q <= '0;
    end
    if (cmd_i.sqrt_en) begin
      if (!trial[41]) begin
        rem_q <= trial;
        root_q <= {root_q[20:0], 1'b1};
      end else begin
        rem_q <= {rem_q[39:0], sq_q[43:42]};
        root_q <= {root_q[20:0], 1'b0};
      end
      sq_q <= {sq_q[41:0], 2'b00};
    end
    if (cmd_i.den) begin
      den_q <= 38'(root_q) * 38'(divisor);
      arrived_o <= (adx < ArriveQ) && (ady < ArriveQ);
    end
    if (cmd_i.divx_en || cmd_i.divy_en) begin
      if (!dtrial[38]) begin
        drem_q <= dtrial[37:0];
        quo_q <= {quo_q[35:0], 1'b1};
      end else begin
        drem_q <= {drem_q[36:0], num_q[36]};
        quo_q <= {quo_q[35:0], 1'b0};
      end
      num_q <= {num_q[35:0], 1'b0};
    end
    // The y division starts on the cycle that finishes the x division.
    if (cmd_i.divx_init || cmd_i.divy_init) begin
      num_q <= {cmd_i.divx_init ? adx : ady, 16'd0};
      drem_q <= '0;
      quo_q <= '0;
    end
    if (cmd_i.divy_init) qx_q <= (den_q == 38'd0) ? 38'sd0 :
      (dx_q[20] ? -38'(quo_q_next_fn(quo_q, dtrial)) : 38'(quo_q_next_fn(quo_q, dtrial)));
    if (cmd_i.acc) begin
      ax_q <= sat20(24'(mulc(21'(ax_q), DecayQ)) + sat_q(qx_q));
      ay_q <= sat20(24'(mulc(21'(ay_q), DecayQ)) +
        ((den_q == 38'd0) ? 24'sd0 : sat_q(dy_q[20] ? -38'(quo_q) : 38'(quo_q))));
    end
    if (cmd_i.vel) begin
      vx_q <= sat20(24'(vx_q) + 24'(ax_q));
      vy_q <= sat20(24'(vy_q) + 24'(ay_q));
    end
    if (cmd_i.damp) begin
      vx_q <= sat20(24'(mulc(21'(vx_q), DampQ)));
      vy_q <= sat20(24'(mulc(21'(vy_q), DampQ)));
    end
    if (cmd_i.pos) begin
      px_q <= px_n;
      py_q <= py_n;
    end
  end

  assign result_index_o = idx_q;
  assign position_x_o = px_q;
  assign position_y_o = py_q;
endmodule

[src/homing_particle_step.sv]
// Homing particle step: a start gives its result in the cycle after its transfer, and a step
// gives it after read, load, 22 square-root steps, denominator, two 37-step divisions,
// four update steps and result. The block takes one item at a time: a new transfer is not
// accepted until the result of the last one has been given.
// Reset (rst_ni low, asynchronous) returns the controller to idle and the smoothing
// divisor to 100; the particle memory is not cleared. The receiver cannot stall.
`include "homing_particle_step_assert.svh"
module homing_particle_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               command_i,
  input  logic [7:0]         particle_index_i,
  input  logic signed [19:0] source_x_i,
  input  logic signed [19:0] source_y_i,
  input  logic signed [19:0] target_x_i,
  input  logic signed [19:0] target_y_i,
  output logic               result_valid_o,
  output logic [7:0]         result_index_o,
  output logic signed [19:0] position_x_o,
  output logic signed [19:0] position_y_o,
  output logic               arrived_o
);
  import hps_pkg::*;
  cmd_t cmd;
  logic accept;

  // A transfer is accepted when start is high while the block is idle.
  assign accept = start && !busy;

  hps_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (accept),
    .cmd_i  (command_i),
    .busy   (busy),
    .done_o (result_valid_o),
    .cmd_o  (cmd)
  );

  hps_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .start            (accept),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .particle_index_i (particle_index_i),
    .source_x_i       (source_x_i),
    .source_y_i       (source_y_i),
    .target_x_i       (target_x_i),
    .target_y_i       (target_y_i),
    .result_index_o   (result_index_o),
    .position_x_o     (position_x_o),
    .position_y_o     (position_y_o),
    .arrived_o        (arrived_o)
  );

  // A result strobe is always followed by an idle cycle.
  `HPS_ASSERT_IMPL(a_done_idle, clk_i, rst_ni, result_valid_o |=> !busy)
  // An accepted transfer makes the block busy next cycle.
  `HPS_ASSERT_IMPL(a_accept_busy, clk_i, rst_ni, accept |=> busy)
endmodule
